/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the route origin validator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted (active low).
`define ROV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define ROV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ROV_ASSERT(lbl, clk, rst_n, prop, msg)
`define ROV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/rov_pkg.sv */
// ----------------------------------------------------------------------------
// rov_pkg
// Types and constants of the route origin validator.
// ----------------------------------------------------------------------------
package rov_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_PATH   = 2'd1,
        CMD_VRP    = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_ASN   = 2'd2
    } phase_t;

    localparam logic [7:0] SEG_SET             = 8'd1;
    localparam logic [7:0] SEG_SEQUENCE        = 8'd2;
    localparam logic [7:0] SEG_CONFED_SEQUENCE = 8'd3;
    localparam logic [7:0] SEG_CONFED_SET      = 8'd4;

    localparam logic [1:0] ASN_LAST_BYTE = 2'd3;

    localparam logic [1:0] VERDICT_NOT_FOUND = 2'd0;
    localparam logic [1:0] VERDICT_VALID     = 2'd1;
    localparam logic [1:0] VERDICT_REJECT    = 2'd2;

    typedef struct packed {
        logic        ok;
        logic [31:0] as_num;
    } origin_t;

    typedef struct packed {
        logic covered;
        logic match;
    } vrp_flags_t;

endpackage

/* hw/rtl/route_origin_validator_top.sv */
// ----------------------------------------------------------------------------
// route_origin_validator_top
// Route origin validation of one route at a time over a stream channel.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one command per transfer, kind in s_tuser:
//   start (loads the prefix length, clears per-route state), path byte
//   (one AS_PATH byte), VRP entry, finish. Only finish produces a result
//   transfer on the master channel: verdict, origin AS and origin flag.
//   Every command is registered, then applied to the route state; a finish
//   result is loaded into the result register, which drives m_tvalid. One
//   command per cycle is sustained while no finish waits; the loop that
//   sets this is the parser and VRP flag update, one byte or entry per cycle.
//   Path bytes and VRP entries keep flowing while a result waits; only a
//   finish that meets a full result register waits in the input register,
//   and s_tready falls once that register is held.
//   Reset (aresetn low, synchronous) empties both registers and returns
//   the route state to its cleared form.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module route_origin_validator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] prefix_len, [15:8] path_byte, [23:16] vrp_len,
    // [31:24] vrp_limit, [63:32] vrp_as, [64] list_present
    input  logic [71:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] verdict, [33:2] origin_as, [34] origin_found
    output logic [39:0] m_tdata
);

    logic          in_valid_reg;
    rov_pkg::cmd_t cmd_reg;
    logic [7:0]    prefix_len_reg;
    logic [7:0]    path_byte_reg;
    logic [7:0]    vrp_len_reg;
    logic [7:0]    vrp_limit_reg;
    logic [31:0]   vrp_as_reg;
    logic          list_present_reg;

    logic advance;
    logic slot_free;
    logic in_take;

    rov_pkg::origin_t    origin;
    rov_pkg::vrp_flags_t flags;

    assign advance  = in_valid_reg && ((cmd_reg != rov_pkg::CMD_FINISH) || slot_free);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            cmd_reg          <= rov_pkg::cmd_t'(s_tuser);
            prefix_len_reg   <= s_tdata[7:0];
            path_byte_reg    <= s_tdata[15:8];
            vrp_len_reg      <= s_tdata[23:16];
            vrp_limit_reg    <= s_tdata[31:24];
            vrp_as_reg       <= s_tdata[63:32];
            list_present_reg <= s_tdata[64];
        end
    end

    rov_path_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (advance && (cmd_reg == rov_pkg::CMD_START)),
        .byte_en   (advance && (cmd_reg == rov_pkg::CMD_PATH)),
        .path_byte (path_byte_reg),
        .origin    (origin)
    );

    rov_vrp_check u_vrp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (advance && (cmd_reg == rov_pkg::CMD_START)),
        .prefix_len  (prefix_len_reg),
        .vrp_en      (advance && (cmd_reg == rov_pkg::CMD_VRP)),
        .vrp_len     (vrp_len_reg),
        .vrp_limit   (vrp_limit_reg),
        .vrp_as      (vrp_as_reg),
        .origin      (origin),
        .flags       (flags)
    );

    rov_result u_result (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (advance && (cmd_reg == rov_pkg::CMD_FINISH)),
        .list_present (list_present_reg),
        .origin       (origin),
        .flags        (flags),
        .slot_free    (slot_free),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    `ROV_ASSERT(a_held_cmd_kept, aclk, aresetn,
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(cmd_reg)),
        "held command lost before it was applied")
    `ROV_ASSERT(a_valid_has_origin, aclk, aresetn,
        (m_tvalid && (m_tdata[1:0] == rov_pkg::VERDICT_VALID)) |-> m_tdata[34],
        "valid verdict without an origin")
    `ROV_ASSERT(a_no_origin_zero, aclk, aresetn,
        (m_tvalid && !m_tdata[34]) |-> (m_tdata[33:2] == 32'd0),
        "origin AS not zero while no origin found")

endmodule

/* hw/rtl/rov_path_parser.sv */
// ----------------------------------------------------------------------------
// rov_path_parser
// AS_PATH byte parser; tracks the origin AS of the final non-empty segment when that is a sequence.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rov_path_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             byte_en,
    input  logic [7:0]       path_byte,
    output rov_pkg::origin_t origin
);

    rov_pkg::phase_t phase_reg, phase_next;
    logic        seq_reg, seq_next;
    logic        type_bad_reg, type_bad_next;
    logic [7:0]  asns_left_reg, asns_left_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] last_origin_reg, last_origin_next;
    logic        origin_valid_reg, origin_valid_next;
    logic        path_bad_reg, path_bad_next;

    logic [31:0] acc_shift;
    logic [7:0]  asns_dec;
    logic        is_seq_type;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= rov_pkg::PH_TYPE;
            seq_reg          <= 1'b0;
            type_bad_reg     <= 1'b0;
            asns_left_reg    <= 8'd0;
            byte_idx_reg     <= 2'd0;
            acc_reg          <= 32'd0;
            last_origin_reg  <= 32'd0;
            origin_valid_reg <= 1'b0;
            path_bad_reg     <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            seq_reg          <= seq_next;
            type_bad_reg     <= type_bad_next;
            asns_left_reg    <= asns_left_next;
            byte_idx_reg     <= byte_idx_next;
            acc_reg          <= acc_next;
            last_origin_reg  <= last_origin_next;
            origin_valid_reg <= origin_valid_next;
            path_bad_reg     <= path_bad_next;
        end
    end

    assign acc_shift   = {acc_reg[23:0], path_byte};
    assign asns_dec    = asns_left_reg - 8'd1;
    assign is_seq_type = (path_byte == rov_pkg::SEG_SEQUENCE) ||
                         (path_byte == rov_pkg::SEG_CONFED_SEQUENCE);

    always_comb begin
        phase_next        = phase_reg;
        seq_next          = seq_reg;
        type_bad_next     = type_bad_reg;
        asns_left_next    = asns_left_reg;
        byte_idx_next     = byte_idx_reg;
        acc_next          = acc_reg;
        last_origin_next  = last_origin_reg;
        origin_valid_next = origin_valid_reg;
        path_bad_next     = path_bad_reg;

        if (clear) begin
            phase_next        = rov_pkg::PH_TYPE;
            seq_next          = 1'b0;
            type_bad_next     = 1'b0;
            asns_left_next    = 8'd0;
            byte_idx_next     = 2'd0;
            acc_next          = 32'd0;
            last_origin_next  = 32'd0;
            origin_valid_next = 1'b0;
            path_bad_next     = 1'b0;
        end else if (byte_en && !path_bad_reg) begin
            unique case (phase_reg)
                rov_pkg::PH_COUNT: begin
                    if (path_byte == 8'd0) begin
                        // empty segment: skipped whatever its type
                        phase_next = rov_pkg::PH_TYPE;
                    end else if (type_bad_reg) begin
                        path_bad_next = 1'b1;
                        phase_next    = rov_pkg::PH_TYPE;
                    end else begin
                        asns_left_next = path_byte;
                        byte_idx_next  = 2'd0;
                        acc_next       = 32'd0;
                        if (!seq_reg) begin
                            origin_valid_next = 1'b0;
                        end
                        phase_next = rov_pkg::PH_ASN;
                    end
                end
                rov_pkg::PH_ASN: begin
                    acc_next = acc_shift;
                    if (byte_idx_reg == rov_pkg::ASN_LAST_BYTE) begin
                        byte_idx_next  = 2'd0;
                        asns_left_next = asns_dec;
                        if (asns_dec == 8'd0) begin
                            if (seq_reg) begin
                                last_origin_next  = acc_shift;
                                origin_valid_next = 1'b1;
                            end
                            phase_next = rov_pkg::PH_TYPE;
                        end
                    end else begin
                        byte_idx_next = byte_idx_reg + 2'd1;
                    end
                end
                default: begin
                    seq_next      = is_seq_type;
                    type_bad_next = !(is_seq_type ||
                                      (path_byte == rov_pkg::SEG_SET) ||
                                      (path_byte == rov_pkg::SEG_CONFED_SET));
                    phase_next    = rov_pkg::PH_COUNT;
                end
            endcase
        end
    end

    // origin only counts when no segment is half read
    assign origin.ok     = origin_valid_reg && !path_bad_reg &&
                           (phase_reg != rov_pkg::PH_COUNT) &&
                           (phase_reg != rov_pkg::PH_ASN);
    assign origin.as_num = last_origin_reg;

    `ROV_ASSERT(a_asn_count_live, aclk, aresetn,
        (phase_reg == rov_pkg::PH_ASN) |-> (asns_left_reg != 8'd0),
        "ASN phase with no ASNs left")
    `ROV_ASSERT(a_bad_path_parked, aclk, aresetn,
        path_bad_reg |-> (phase_reg == rov_pkg::PH_TYPE),
        "bad path left parser mid segment")
    `ROV_ASSERT(a_origin_from_asn, aclk, aresetn,
        $rose(origin_valid_reg) |-> $past(phase_reg == rov_pkg::PH_ASN),
        "origin set outside ASN phase")

endmodule

/* hw/rtl/rov_vrp_check.sv */
// ----------------------------------------------------------------------------
// rov_vrp_check
// Per-route VRP coverage and match tracking.
// ----------------------------------------------------------------------------
module rov_vrp_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [7:0]          prefix_len,
    input  logic                vrp_en,
    input  logic [7:0]          vrp_len,
    input  logic [7:0]          vrp_limit,
    input  logic [31:0]         vrp_as,
    input  rov_pkg::origin_t    origin,
    output rov_pkg::vrp_flags_t flags
);

    logic [7:0] route_len_reg;
    logic       covered_reg;
    logic       match_reg;
    logic       covers;
    logic       hit;

    assign covers = (vrp_len <= route_len_reg);
    assign hit    = covers && (route_len_reg <= vrp_limit) && origin.ok &&
                    (vrp_as == origin.as_num);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_len_reg <= 8'd0;
            covered_reg   <= 1'b0;
            match_reg     <= 1'b0;
        end else if (start) begin
            route_len_reg <= prefix_len;
            covered_reg   <= 1'b0;
            match_reg     <= 1'b0;
        end else if (vrp_en) begin
            covered_reg <= covered_reg | covers;
            match_reg   <= match_reg | hit;
        end
    end

    assign flags.covered = covered_reg;
    assign flags.match   = match_reg;

endmodule

/* hw/rtl/rov_result.sv */
// ----------------------------------------------------------------------------
// rov_result
// Verdict decision and result register of the output stream.
// ----------------------------------------------------------------------------
module rov_result (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic                list_present,
    input  rov_pkg::origin_t    origin,
    input  rov_pkg::vrp_flags_t flags,
    output logic                slot_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata
);

    logic        valid_reg;
    logic [1:0]  verdict_reg, verdict_next;
    logic [31:0] as_reg;
    logic        found_reg;

    always_comb begin
        if (!list_present) begin
            verdict_next = rov_pkg::VERDICT_NOT_FOUND;
        end else if (!origin.ok) begin
            verdict_next = rov_pkg::VERDICT_REJECT;
        end else if (flags.match) begin
            verdict_next = rov_pkg::VERDICT_VALID;
        end else if (flags.covered) begin
            verdict_next = rov_pkg::VERDICT_REJECT;
        end else begin
            verdict_next = rov_pkg::VERDICT_NOT_FOUND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            verdict_reg <= verdict_next;
            as_reg      <= origin.ok ? origin.as_num : 32'd0;
            found_reg   <= origin.ok;
        end
    end

    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {5'd0, found_reg, as_reg, verdict_reg};

endmodule

/* bench/route_origin_validator_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// route_origin_validator_top_tb
// Self-checking bench for the route origin validator. Routes are streamed
// as start, AS_PATH bytes, VRP entries and finish commands. An in-bench
// model of the path parser and VRP checks predicts each finish verdict.
// Each result transfer is compared field by field with the oldest
// prediction. Both channels idle at random, and the result side is held
// off for a long stretch so that the input side fills and stalls.
// ----------------------------------------------------------------------------
module route_origin_validator_top_tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int IDLE_PERCENT = 17;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] origin_as;
        logic        origin_found;
    } verdict_rec_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [7:0] prefix_len, [15:8] path_byte, [23:16] vrp_len,
    // [31:24] vrp_limit, [63:32] vrp_as, [64] list_present
    logic [71:0] s_tdata  = '0;
    // [1:0] cmd
    logic [1:0]  s_tuser  = rov_pkg::CMD_START;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [1:0] verdict, [33:2] origin_as, [34] origin_found
    logic [39:0] m_tdata;

    // route state of the bench model
    rov_pkg::phase_t route_phase;
    logic        seg_is_seq;
    logic        seg_type_bad;
    logic [7:0]  asns_left;
    logic [1:0]  asn_byte_idx;
    logic [31:0] asn_acc;
    logic [31:0] last_origin;
    logic        origin_valid;
    logic        path_bad;
    logic [7:0]  route_len;
    logic        any_covered;
    logic        any_match;

    verdict_rec_t expected_verdicts[$];

    int  error_count   = 0;
    int  result_count  = 0;
    int  items_sent    = 0;
    int  cycle_count   = 0;
    int  hold_request  = 0;
    int  hold_left     = 0;
    bit  no_idle       = 1'b0;

    logic [31:0] asn_pool [4] = '{32'd64512, 32'd65535, 32'd13335, 32'h0001_0000};

    route_origin_validator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Bench model of the route state
    // ------------------------------------------------------------------
    task automatic clear_route_state();
        route_phase  = rov_pkg::PH_TYPE;
        seg_is_seq   = 1'b0;
        seg_type_bad = 1'b0;
        asns_left    = '0;
        asn_byte_idx = '0;
        asn_acc      = '0;
        last_origin  = '0;
        origin_valid = 1'b0;
        path_bad     = 1'b0;
        route_len    = '0;
        any_covered  = 1'b0;
        any_match    = 1'b0;
    endtask

    function automatic logic origin_usable();
        return origin_valid && !path_bad && route_phase != rov_pkg::PH_COUNT &&
               route_phase != rov_pkg::PH_ASN;
    endfunction

    task automatic parse_path_byte(input logic [7:0] b);
        if (!path_bad) begin
            case (route_phase)
                rov_pkg::PH_COUNT: begin
                    if (b == 8'd0) begin
                        route_phase = rov_pkg::PH_TYPE;
                    end else if (seg_type_bad) begin
                        path_bad    = 1'b1;
                        route_phase = rov_pkg::PH_TYPE;
                    end else begin
                        asns_left    = b;
                        asn_byte_idx = '0;
                        asn_acc      = '0;
                        // a non-empty set drops any origin seen so far
                        if (!seg_is_seq)
                            origin_valid = 1'b0;
                        route_phase = rov_pkg::PH_ASN;
                    end
                end
                rov_pkg::PH_ASN: begin
                    asn_acc = {asn_acc[23:0], b};
                    if (asn_byte_idx >= rov_pkg::ASN_LAST_BYTE) begin
                        asn_byte_idx = '0;
                        asns_left    = asns_left - 8'd1;
                        if (asns_left == 8'd0) begin
                            if (seg_is_seq) begin
                                last_origin  = asn_acc;
                                origin_valid = 1'b1;
                            end
                            route_phase = rov_pkg::PH_TYPE;
                        end
                    end else begin
                        asn_byte_idx = asn_byte_idx + 2'd1;
                    end
                end
                default: begin
                    seg_is_seq   = (b == rov_pkg::SEG_SEQUENCE ||
                                    b == rov_pkg::SEG_CONFED_SEQUENCE);
                    seg_type_bad = !(seg_is_seq || b == rov_pkg::SEG_SET ||
                                     b == rov_pkg::SEG_CONFED_SET);
                    route_phase  = rov_pkg::PH_COUNT;
                end
            endcase
        end
    endtask

    task automatic apply_command(input rov_pkg::cmd_t cmd, input logic [71:0] d);
        verdict_rec_t rec;
        logic found;
        case (cmd)
            rov_pkg::CMD_START: begin
                clear_route_state();
                route_len = d[7:0];
            end
            rov_pkg::CMD_PATH: parse_path_byte(d[15:8]);
            rov_pkg::CMD_VRP: begin
                if (d[23:16] <= route_len) begin
                    any_covered = 1'b1;
                    if (route_len <= d[31:24] && origin_usable() && d[63:32] == last_origin)
                        any_match = 1'b1;
                end
            end
            default: begin
                found = origin_usable();
                if (!d[64])
                    rec.verdict = rov_pkg::VERDICT_NOT_FOUND;
                else if (!found)
                    rec.verdict = rov_pkg::VERDICT_REJECT;
                else if (any_match)
                    rec.verdict = rov_pkg::VERDICT_VALID;
                else if (any_covered)
                    rec.verdict = rov_pkg::VERDICT_REJECT;
                else
                    rec.verdict = rov_pkg::VERDICT_NOT_FOUND;
                rec.origin_as    = found ? last_origin : 32'd0;
                rec.origin_found = found;
                expected_verdicts.push_back(rec);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d, result %0d: %s", cycle_count, result_count, msg);
        error_count++;
    endtask

    task automatic check_verdict(input logic [39:0] r);
        verdict_rec_t want;
        if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", r));
        end else begin
            want = expected_verdicts.pop_front();
            if (r[1:0] !== want.verdict)
                report_mismatch($sformatf("verdict %0d, expected %0d", r[1:0], want.verdict));
            if (r[33:2] !== want.origin_as)
                report_mismatch($sformatf("origin_as %h, expected %h", r[33:2], want.origin_as));
            if (r[34] !== want.origin_found)
                report_mismatch($sformatf("origin_found %b, expected %b", r[34],
                                          want.origin_found));
        end
        result_count++;
    endtask

    // results first: a result never belongs to a finish taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_route_state();
        end else begin
            if (m_tvalid && m_tready)
                check_verdict(m_tdata);
            if (s_tvalid && s_tready)
                apply_command(rov_pkg::cmd_t'(s_tuser), s_tdata);
        end
    end

    // result side ready; a hold-off request is counted down here
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [71:0] rand_payload();
        return {7'd0, 1'($urandom), 32'($urandom), 32'($urandom)};
    endfunction

    task automatic send_item(input rov_pkg::cmd_t cmd, input logic [71:0] d);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_start(input logic [7:0] plen);
        logic [71:0] d;
        d       = rand_payload();
        d[7:0]  = plen;
        send_item(rov_pkg::CMD_START, d);
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic [71:0] d;
        d       = rand_payload();
        d[15:8] = b;
        send_item(rov_pkg::CMD_PATH, d);
    endtask

    task automatic send_asn(input logic [31:0] asn);
        send_byte(asn[31:24]);
        send_byte(asn[23:16]);
        send_byte(asn[15:8]);
        send_byte(asn[7:0]);
    endtask

    task automatic send_vrp(input logic [7:0] vlen, input logic [7:0] vmax,
                            input logic [31:0] vas);
        logic [71:0] d;
        d        = rand_payload();
        d[23:16] = vlen;
        d[31:24] = vmax;
        d[63:32] = vas;
        send_item(rov_pkg::CMD_VRP, d);
    endtask

    task automatic send_finish(input logic list_present);
        logic [71:0] d;
        d     = rand_payload();
        d[64] = list_present;
        send_item(rov_pkg::CMD_FINISH, d);
    endtask

    // drop valid, then wait out every outstanding verdict
    task automatic pause_for_results();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (expected_verdicts.size() != 0);
    endtask

    function automatic logic [31:0] pick_asn();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3, 4, 5: return asn_pool[$urandom_range(3)];
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_seg_type();
        int r;
        r = $urandom_range(19);
        if (r < 7)       return rov_pkg::SEG_SEQUENCE;
        else if (r < 10) return rov_pkg::SEG_CONFED_SEQUENCE;
        else if (r < 13) return rov_pkg::SEG_SET;
        else if (r < 16) return rov_pkg::SEG_CONFED_SET;
        else if (r < 18) return 8'($urandom_range(255));
        else             return 8'd0;
    endfunction

    task automatic send_random_vrp(input logic [7:0] plen, input logic [31:0] last_as);
        logic [7:0]  vlen;
        logic [7:0]  vmax;
        logic [31:0] vas;
        int r;
        r = $urandom_range(9);
        vas = (r < 5) ? last_as : (r < 7) ? asn_pool[$urandom_range(3)] : 32'($urandom);
        r = $urandom_range(19);
        if (r < 12)      vlen = 8'($urandom_range(plen, 0));
        else if (r < 16) vlen = 8'($urandom_range(255, plen));
        else             vlen = 8'($urandom_range(255));
        r = $urandom_range(19);
        if (r < 11)      vmax = 8'($urandom_range(plen > 8'd128 ? plen : 8'd128, plen));
        else if (r < 16) vmax = 8'($urandom_range(plen, 0));
        else             vmax = 8'($urandom_range(255));
        send_vrp(vlen, vmax, vas);
    endtask

    // one route with random content, sometimes malformed, truncated or noisy
    task automatic send_random_route();
        logic [7:0]  plen;
        logic [7:0]  stype;
        logic [31:0] asn;
        logic [31:0] last_as;
        int nseg, cnt, cut;
        bit gone_bad;
        last_as  = asn_pool[$urandom_range(3)];
        gone_bad = 1'b0;
        plen = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(128));
        send_start(plen);
        if ($urandom_range(4) == 0)
            send_random_vrp(plen, last_as);
        nseg = $urandom_range(3);
        for (int k = 0; k < nseg && !gone_bad; k++) begin
            stype = pick_seg_type();
            cnt   = ($urandom_range(7) == 0) ? 0 : $urandom_range(3, 1);
            send_byte(stype);
            send_byte(8'(cnt));
            // unknown non-empty segment: the rest of the path is ignored
            if (cnt != 0 && !(stype >= rov_pkg::SEG_SET && stype <= rov_pkg::SEG_CONFED_SET)) begin
                gone_bad = 1'b1;
            end else begin
                for (int j = 0; j < cnt; j++) begin
                    asn = pick_asn();
                    send_asn(asn);
                    last_as = asn;
                end
            end
        end
        if (!gone_bad && $urandom_range(7) == 0) begin
            // truncated tail: finish comes while a count or ASN bytes are due
            send_byte(pick_seg_type());
            if ($urandom_range(1) == 1) begin
                cnt = $urandom_range(255, 1);
                send_byte(8'(cnt));
                cut = $urandom_range((cnt * 4 - 1) < 7 ? (cnt * 4 - 1) : 7);
                repeat (cut) send_byte(8'($urandom_range(255)));
            end
        end
        repeat ($urandom_range(4)) send_random_vrp(plen, last_as);
        send_finish($urandom_range(6) != 0);
        if ($urandom_range(9) == 0)
            send_finish(1'($urandom_range(1)));
        if ($urandom_range(19) == 0)
            pause_for_results();
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(4, 1))
                send_item(rov_pkg::cmd_t'($urandom_range(3)), rand_payload());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        // finish on the reset state, before any start
        send_finish(1'b1);
        // confed sequence origin, empty unknown segment skipped,
        // out-of-range VRP length not covering, exact match
        send_start(8'd128);
        send_byte(rov_pkg::SEG_CONFED_SEQUENCE);
        send_byte(8'd1);
        send_asn(32'hFFFF_FFFF);
        send_byte(8'd7);
        send_byte(8'd0);
        send_vrp(8'd255, 8'd255, 32'hFFFF_FFFF);
        send_vrp(8'd0, 8'd128, 32'hFFFF_FFFF);
        send_finish(1'b1);
        // unknown non-empty segment: path bad, later bytes ignored
        send_start(8'd255);
        send_byte(8'hFF);
        send_byte(8'd2);
        send_byte(rov_pkg::SEG_SEQUENCE);
        send_byte(8'd1);
        send_vrp(8'd255, 8'd0, 32'd0);
        send_finish(1'b1);
        // truncated path, then a repeated finish, the second without a list
        send_start(8'd24);
        send_byte(rov_pkg::SEG_SEQUENCE);
        send_byte(8'd255);
        send_byte(8'd0);
        send_finish(1'b1);
        send_finish(1'b0);
        pause_for_results();
    endtask

    task automatic test_random_routes(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            send_random_route();
    endtask

    task automatic test_streaming_no_gaps(input int n_items);
        no_idle = 1'b1;
        test_random_routes(n_items);
        no_idle = 1'b0;
    endtask

    // result side held off while finishes keep coming: the input stalls
    task automatic test_result_stall();
        no_idle      = 1'b1;
        hold_request = 400;
        repeat (5) send_random_route();
        pause_for_results();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_routes(600);
        test_streaming_no_gaps(200);
        test_result_stall();
        test_random_routes(300);
        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_verdicts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rov_pkg.sv
hw/rtl/rov_path_parser.sv
hw/rtl/rov_vrp_check.sv
hw/rtl/rov_result.sv
hw/rtl/route_origin_validator_top.sv
bench/route_origin_validator_top_tb.sv
